>>> rtl/lane_fit_delayed_moving_average_macros.svh
// Assertion helpers for the lane fit averaging block.
// Both sample on the rising edge of clk and stand down while rst is high.
`ifndef LANE_FIT_DELAYED_MOVING_AVERAGE_MACROS_SVH
`define LANE_FIT_DELAYED_MOVING_AVERAGE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define LDMA_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LDMA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ldma_pkg.sv
package ldma_pkg;

  // Coefficients per lane fit: constant, linear, quadratic.
  localparam int unsigned NUM_COEF   = 3;
  localparam int unsigned PORT_BITS  = 32;
  localparam int unsigned WIDTH_BITS = 31;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

  // Quotient bits resolved per divider cycle.
  localparam int unsigned DIV_STEP = 4;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_CHECK,
    LN_COMPARE,
    LN_OLD,
    LN_ENTER,
    LN_DIV_START,
    LN_DIV_WAIT
  } lane_state_t;

  typedef enum logic [2:0] {
    TP_IDLE,
    TP_LANES,
    TP_DIFF,
    TP_WIDTH,
    TP_PUBLISH
  } top_state_t;

  typedef struct packed {
    logic start;
    logic restart;
  } lane_ctrl_t;

endpackage

>>> rtl/ldma_div.sv
module ldma_div #(
  parameter int NUM_BITS = 37,
  parameter int DEN_BITS = 5,
  parameter int QUO_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] dividend,
  input  logic        [DEN_BITS-1:0] divisor,
  output logic                       done,
  output logic        [QUO_BITS-1:0] quotient
);
  import ldma_pkg::*;

  localparam int ITER  = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD   = ITER * DIV_STEP;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [CNT_W-1:0]    cnt;
  logic [PAD-1:0]      num;
  logic [PAD-1:0]      quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic                neg;

  logic [NUM_BITS-1:0] mag;
  logic [DEN_BITS-1:0] rem_step;
  logic [DIV_STEP-1:0] q_bits;
  logic [PAD-1:0]      quo_signed;

  // Divide magnitudes; fix the sign at the end for truncation toward zero.
  assign mag = dividend[NUM_BITS-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    logic [DEN_BITS:0] r;
    r      = {1'b0, rem};
    q_bits = '0;
    for (int j = 0; j < DIV_STEP; j++) begin
      r = {r[DEN_BITS-1:0], num[PAD-1-j]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q_bits[DIV_STEP-1-j] = 1'b1;
      end
    end
    rem_step = r[DEN_BITS-1:0];
  end

  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[QUO_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(ITER);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= PAD'(mag);
      quo <= '0;
      rem <= '0;
      den <= divisor;
      neg <= dividend[NUM_BITS-1];
    end else if (cnt != '0) begin
      num <= num << DIV_STEP;
      quo <= {quo[PAD-DIV_STEP-1:0], q_bits};
      rem <= rem_step;
    end
  end

endmodule

>>> rtl/ldma_lane.sv
module ldma_lane #(
  parameter int WINDOW_LENGTH = 20,
  parameter int DELAY_LENGTH  = 3,
  parameter int IN_BITS       = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  ldma_pkg::lane_ctrl_t                      ctrl,
  input  logic [ldma_pkg::NUM_COEF-1:0][IN_BITS-1:0] fit,
  output logic                                      busy,
  output logic [ldma_pkg::NUM_COEF-1:0][IN_BITS-1:0] avg
);
  import ldma_pkg::*;

  localparam int RING_LEN = WINDOW_LENGTH + DELAY_LENGTH;
  localparam int CW       = $clog2(RING_LEN + 1);
  localparam int PW       = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
  localparam int DW       = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W    = IN_BITS + DW;

  localparam logic [CW-1:0] RING_CNT  = CW'(RING_LEN);
  localparam logic [CW-1:0] WIN_CNT   = CW'(WINDOW_LENGTH);
  localparam logic [DW-1:0] WIN_DIV   = DW'(WINDOW_LENGTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_LEN - 1);
  localparam logic [PW:0]   RING_EXT  = (PW + 1)'(RING_LEN);
  localparam logic [PW:0]   WIN_EXT   = (PW + 1)'(WINDOW_LENGTH);

  typedef logic [NUM_COEF-1:0][IN_BITS-1:0] row_t;

  lane_state_t state, state_next;

  row_t                    ring [RING_LEN];
  row_t                    rd_data;
  row_t                    fit_q;
  row_t                    old_q;
  logic                    restart_q;
  logic [CW-1:0]           count;
  logic [PW-1:0]           pos;
  logic signed [SUM_W-1:0] sum [NUM_COEF];
  logic [DW-1:0]           divisor;
  logic [1:0]              coef_idx;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic          div_start;
  logic          div_done;
  logic [IN_BITS-1:0] div_quot;

  logic          full;
  logic          fresh;
  logic          match;
  logic          fill_in_window;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [PW-1:0] newest_addr;
  logic [PW:0]   enter_wide;
  logic [PW:0]   enter_wrap;
  logic [PW-1:0] enter_addr;
  row_t          enter_val;

  assign full           = (count == RING_CNT);
  assign fresh          = restart_q || (count == '0);
  assign match          = (rd_data == fit_q);
  assign count_inc      = count + 1'b1;
  assign count_dec      = count - 1'b1;
  assign fill_in_window = (count_inc <= WIN_CNT);
  assign newest_addr    = (pos == '0) ? LAST_SLOT : pos - 1'b1;
  assign enter_wide     = {1'b0, pos} + WIN_EXT;
  assign enter_wrap     = enter_wide - RING_EXT;
  assign enter_addr     = (enter_wide >= RING_EXT) ? enter_wrap[PW-1:0] : enter_wide[PW-1:0];
  // With no delay the entering entry is the fit being written.
  assign enter_val      = (DELAY_LENGTH == 0) ? fit_q : rd_data;
  assign busy           = (state != LN_IDLE);

  // History ring: one row per recorded fit, all three coefficients side by side.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= fit_q;
    end
    if (mem_re) begin
      rd_data <= ring[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      LN_IDLE:      if (ctrl.start) state_next = LN_CHECK;
      LN_CHECK:     state_next = fresh ? LN_IDLE : LN_COMPARE;
      LN_COMPARE: begin
        if (match) begin
          state_next = LN_IDLE;
        end else if (full) begin
          state_next = LN_OLD;
        end else begin
          state_next = LN_DIV_START;
        end
      end
      LN_OLD:       state_next = LN_ENTER;
      LN_ENTER:     state_next = LN_DIV_START;
      LN_DIV_START: state_next = LN_DIV_WAIT;
      LN_DIV_WAIT: begin
        if (div_done) begin
          state_next = (coef_idx == 2'(NUM_COEF - 1)) ? LN_IDLE : LN_DIV_START;
        end
      end
      default:      state_next = LN_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    div_start = 1'b0;
    case (state)
      LN_CHECK: begin
        if (fresh) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = full ? newest_addr : count_dec[PW-1:0];
        end
      end
      LN_COMPARE: begin
        if (!match && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[PW-1:0];
        end else if (!match) begin
          mem_re    = 1'b1;
          mem_raddr = pos;
        end
      end
      LN_OLD: begin
        mem_re    = 1'b1;
        mem_raddr = enter_addr;
      end
      LN_ENTER: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
      end
      LN_DIV_START: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
      for (int k = 0; k < NUM_COEF; k++) begin
        sum[k] <= '0;
        avg[k] <= '0;
      end
    end else begin
      case (state)
        LN_CHECK: begin
          if (fresh) begin
            count <= CW'(1);
            pos   <= '0;
            for (int k = 0; k < NUM_COEF; k++) begin
              sum[k] <= SUM_W'($signed(fit_q[k]));
              avg[k] <= fit_q[k];
            end
          end
        end
        LN_COMPARE: begin
          if (!match && !full) begin
            count <= count_inc;
            if (fill_in_window) begin
              for (int k = 0; k < NUM_COEF; k++) begin
                sum[k] <= sum[k] + SUM_W'($signed(fit_q[k]));
              end
            end
          end
        end
        LN_ENTER: begin
          pos <= (pos == LAST_SLOT) ? '0 : pos + 1'b1;
          for (int k = 0; k < NUM_COEF; k++) begin
            sum[k] <= sum[k] - SUM_W'($signed(old_q[k])) + SUM_W'($signed(enter_val[k]));
          end
        end
        LN_DIV_WAIT: begin
          if (div_done) begin
            avg[coef_idx] <= div_quot;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: begin
        if (ctrl.start) begin
          fit_q     <= fit;
          restart_q <= ctrl.restart;
        end
      end
      LN_COMPARE: begin
        divisor  <= fill_in_window ? count_inc[DW-1:0] : WIN_DIV;
        coef_idx <= '0;
      end
      LN_OLD: old_q <= rd_data;
      LN_ENTER: begin
        divisor  <= WIN_DIV;
        coef_idx <= '0;
      end
      LN_DIV_WAIT: begin
        if (div_done) begin
          coef_idx <= coef_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  ldma_div #(
    .NUM_BITS (SUM_W),
    .DEN_BITS (DW),
    .QUO_BITS (IN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum[coef_idx]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

>>> rtl/lane_fit_delayed_moving_average.sv
// Delayed moving average of left and right lane fits. Each input item is one
// frame; each frame gives exactly one result item holding the current
// averaged fits and lane width. A frame with a new fit pair records each fit
// in that lane's ring of WINDOW_LENGTH + DELAY_LENGTH rows, one synchronous
// memory per lane, and averages the oldest WINDOW_LENGTH rows (fewer while
// the ring fills); a fit equal to the newest row is skipped, and a restart
// flag or nonzero branch_grow reloads the ring with the new fit alone.
// Averages are exact sums divided by the row count, truncated toward zero.
// The block takes a new frame only once the result of the last one is in
// the output register. A frame without a new fit goes straight to publish;
// otherwise the top level waits until both lanes are idle, then forms the
// width and publishes. A restart or a skipped repeat ends a lane's work
// early; a recorded fit runs the radix-16 divider in each lane, which
// forms the three quotients one after another over the sum, whose width is
// the coefficient bits plus ceil(log2(WINDOW_LENGTH + 1)), 37 at default
// settings. The lanes run side by side. All memory accesses of a frame
// finish before the next frame is taken, so no two accesses to the same
// row can overlap. The history needs no clearing pass.
`include "lane_fit_delayed_moving_average_macros.svh"

module lane_fit_delayed_moving_average #(
  parameter int WINDOW_LENGTH = 20,
  parameter int DELAY_LENGTH  = 3,
  parameter int COEF_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                has_fit,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] left_c0,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] left_c1,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] left_c2,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] right_c0,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] right_c1,
  input  logic signed [ldma_pkg::PORT_BITS-1:0] right_c2,
  input  logic                                first_frame,
  input  logic                                split_seen,
  input  logic                                new_branch,
  input  logic [7:0]                          branch_grow,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ldma_pkg::PORT_BITS-1:0] left_avg_c0,
  output logic signed [ldma_pkg::PORT_BITS-1:0] left_avg_c1,
  output logic signed [ldma_pkg::PORT_BITS-1:0] left_avg_c2,
  output logic signed [ldma_pkg::PORT_BITS-1:0] right_avg_c0,
  output logic signed [ldma_pkg::PORT_BITS-1:0] right_avg_c1,
  output logic signed [ldma_pkg::PORT_BITS-1:0] right_avg_c2,
  output logic [ldma_pkg::WIDTH_BITS-1:0]      lane_width
);
  import ldma_pkg::*;

  // Coefficients are taken at no more than the port width.
  localparam int IN_BITS = (COEF_WIDTH < PORT_BITS) ? COEF_WIDTH : PORT_BITS;
  localparam int MAG_W   = PORT_BITS + 1;

  top_state_t state, state_next;

  lane_ctrl_t lane_ctrl;
  logic [NUM_COEF-1:0][IN_BITS-1:0] left_trim, right_trim;
  logic [NUM_COEF-1:0][IN_BITS-1:0] left_avg, right_avg;
  logic left_busy, right_busy;

  logic                    accept;
  logic                    load_out;
  logic                    width_hold;
  logic                    both_nz;
  logic signed [IN_BITS:0] diff;
  logic [IN_BITS:0]        diff_mag;
  logic [MAG_W-1:0]        diff_wide;
  logic [WIDTH_BITS-1:0]   width_estimate;

  // Trim each coefficient to the working width.
  assign left_trim[0]  = left_c0[IN_BITS-1:0];
  assign left_trim[1]  = left_c1[IN_BITS-1:0];
  assign left_trim[2]  = left_c2[IN_BITS-1:0];
  assign right_trim[0] = right_c0[IN_BITS-1:0];
  assign right_trim[1] = right_c1[IN_BITS-1:0];
  assign right_trim[2] = right_c2[IN_BITS-1:0];

  // Width of the gap between averaged constant terms, saturated.
  assign diff_mag  = diff[IN_BITS] ? (~diff + 1'b1) : diff;
  assign diff_wide = MAG_W'(diff_mag);

  // Next state: take an item, let both lanes finish, then update the width
  // and publish; an item without a new fit goes straight to publish.
  always_comb begin
    state_next = state;
    case (state)
      TP_IDLE: begin
        if (in_valid) begin
          state_next = has_fit ? TP_LANES : TP_PUBLISH;
        end
      end
      TP_LANES: begin
        if (!left_busy && !right_busy) begin
          state_next = TP_DIFF;
        end
      end
      TP_DIFF:    state_next = TP_WIDTH;
      TP_WIDTH:   state_next = TP_PUBLISH;
      TP_PUBLISH: begin
        if (load_out) begin
          state_next = TP_IDLE;
        end
      end
      default:    state_next = TP_IDLE;
    endcase
  end

  // Outputs of the sequencer: hold off input while a frame is in flight,
  // kick both lanes on a new fit pair, load the output register once free.
  always_comb begin
    in_stall          = (state != TP_IDLE);
    accept            = (state == TP_IDLE) && in_valid;
    lane_ctrl.start   = accept && has_fit;
    lane_ctrl.restart = first_frame || split_seen || new_branch || (branch_grow != '0);
    load_out          = (state == TP_PUBLISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Width estimate: freeze it while the branch grows or a lane averages to
  // an all-zero fit.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_estimate <= '0;
    end else if (state == TP_WIDTH && !width_hold && both_nz) begin
      width_estimate <= (diff_wide > MAG_W'(WIDTH_MAX)) ? WIDTH_MAX
                                                         : diff_wide[WIDTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      width_hold <= (branch_grow != '0);
    end
    if (state == TP_DIFF) begin
      diff    <= (IN_BITS + 1)'($signed(right_avg[0])) - (IN_BITS + 1)'($signed(left_avg[0]));
      both_nz <= (|left_avg) && (|right_avg);
    end
  end

  // Output register: hold the result until taken, drop valid once it goes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_avg_c0  <= PORT_BITS'($signed(left_avg[0]));
      left_avg_c1  <= PORT_BITS'($signed(left_avg[1]));
      left_avg_c2  <= PORT_BITS'($signed(left_avg[2]));
      right_avg_c0 <= PORT_BITS'($signed(right_avg[0]));
      right_avg_c1 <= PORT_BITS'($signed(right_avg[1]));
      right_avg_c2 <= PORT_BITS'($signed(right_avg[2]));
      lane_width   <= width_estimate;
    end
  end

  ldma_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .DELAY_LENGTH  (DELAY_LENGTH),
    .IN_BITS       (IN_BITS)
  ) u_left (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lane_ctrl),
    .fit  (left_trim),
    .busy (left_busy),
    .avg  (left_avg)
  );

  ldma_lane #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .DELAY_LENGTH  (DELAY_LENGTH),
    .IN_BITS       (IN_BITS)
  ) u_right (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lane_ctrl),
    .fit  (right_trim),
    .busy (right_busy),
    .avg  (right_avg)
  );

  // Lanes must be quiet whenever the sequencer is ready for a new item.
  `LDMA_CHECK_NOW(a_lanes_quiet, state == TP_IDLE, !left_busy && !right_busy, "lane busy in idle")
  // A lane only gets busy through a start.
  `LDMA_CHECK_NEXT(a_busy_by_start, !left_busy && !right_busy && !lane_ctrl.start, !left_busy && !right_busy, "lane started on its own")
  // The width moves only in its update step.
  `LDMA_CHECK_NEXT(a_width_steady, state != TP_WIDTH, $stable(width_estimate), "width changed outside update")
  // A result appears only from the publish step.
  `LDMA_CHECK_NOW(a_out_from_publish, $rose(out_valid), $past(state) == TP_PUBLISH, "result raised outside publish")

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import ldma_pkg::*;

  localparam int WINDOW_LENGTH = 20;
  localparam int DELAY_LENGTH  = 3;
  localparam int RING_LEN      = WINDOW_LENGTH + DELAY_LENGTH;
  localparam int RANDOM_FITS   = 1000;
  localparam int MAX_WAIT      = 17;
  localparam int HOLD_OFF_AT   = 200;
  localparam int HOLD_OFF_LEN  = 600;
  localparam int DRAIN_CYCLES  = 100;
  localparam longint WIDTH_SAT = 64'h7FFF_FFFF;
  localparam int C_MAX         = 32'sh7FFF_FFFF;
  localparam int C_MIN         = 32'sh8000_0000;

  // One fit: element 0 is the constant term, 1 linear, 2 quadratic.
  typedef logic [NUM_COEF-1:0][PORT_BITS-1:0] fit_t;

  typedef struct packed {
    logic       has_fit;
    fit_t       left;
    fit_t       right;
    logic       first_frame;
    logic       split_seen;
    logic       new_branch;
    logic [7:0] branch_grow;
  } frame_t;

  typedef struct packed {
    fit_t                  left;
    fit_t                  right;
    logic [WIDTH_BITS-1:0] width;
  } lane_avg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic                        has_fit       = 1'b0;
  logic signed [PORT_BITS-1:0] left_c0       = '0;
  logic signed [PORT_BITS-1:0] left_c1       = '0;
  logic signed [PORT_BITS-1:0] left_c2       = '0;
  logic signed [PORT_BITS-1:0] right_c0      = '0;
  logic signed [PORT_BITS-1:0] right_c1      = '0;
  logic signed [PORT_BITS-1:0] right_c2      = '0;
  logic                        first_frame   = 1'b0;
  logic                        split_seen    = 1'b0;
  logic                        new_branch    = 1'b0;
  logic [7:0]                  branch_grow   = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic signed [PORT_BITS-1:0] left_avg_c0;
  logic signed [PORT_BITS-1:0] left_avg_c1;
  logic signed [PORT_BITS-1:0] left_avg_c2;
  logic signed [PORT_BITS-1:0] right_avg_c0;
  logic signed [PORT_BITS-1:0] right_avg_c1;
  logic signed [PORT_BITS-1:0] right_avg_c2;
  logic [WIDTH_BITS-1:0]       lane_width;

  lane_fit_delayed_moving_average #(
    .WINDOW_LENGTH(WINDOW_LENGTH),
    .DELAY_LENGTH (DELAY_LENGTH),
    .COEF_WIDTH   (32)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .has_fit      (has_fit),
    .left_c0      (left_c0),
    .left_c1      (left_c1),
    .left_c2      (left_c2),
    .right_c0     (right_c0),
    .right_c1     (right_c1),
    .right_c2     (right_c2),
    .first_frame  (first_frame),
    .split_seen   (split_seen),
    .new_branch   (new_branch),
    .branch_grow  (branch_grow),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_avg_c0  (left_avg_c0),
    .left_avg_c1  (left_avg_c1),
    .left_avg_c2  (left_avg_c2),
    .right_avg_c0 (right_avg_c0),
    .right_avg_c1 (right_avg_c1),
    .right_avg_c2 (right_avg_c2),
    .lane_width   (lane_width)
  );

  // Free-running clock; reset is held high from the start, then released.
  initial forever #2 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state, one copy per lane (0 = left, 1 = right).
  // Sums are exact; the ring only ever gets read at slots written since
  // the last restart, so no unwritten entry plays a part.
  // ---------------------------------------------------------------------
  longint ring_hist   [2][RING_LEN][NUM_COEF];
  int     ring_count  [2];
  int     ring_oldest [2];
  longint window_sum  [2][NUM_COEF];
  longint lane_avg    [2][NUM_COEF];
  longint width_est;

  frame_t    frame_pending [$];
  lane_avg_t avg_expected  [$];
  frame_t    cur_frame;
  int        errors       = 0;
  int        results_seen = 0;
  int        fits_queued  = 0;
  int        send_wait    = 0;
  int        recv_wait    = 0;
  bit        send_calm    = 1'b0;
  bit        recv_calm    = 1'b0;
  fit_t      last_left    = '0;
  fit_t      last_right   = '0;

  // Record one lane's fit and refresh that lane's averages.
  function automatic void record_fit(int ln, fit_t fit, bit restart);
    longint f [NUM_COEF];
    longint old;
    int     p, newest, enter, last, n;
    bit     same;
    for (int k = 0; k < NUM_COEF; k++) f[k] = longint'($signed(fit[k]));
    // Empty ring or restart: reload with the new fit alone.
    if (ring_count[ln] == 0 || restart) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        ring_hist[ln][0][k] = f[k];
        window_sum[ln][k]   = f[k];
        lane_avg[ln][k]     = f[k];
      end
      ring_count[ln]  = 1;
      ring_oldest[ln] = 0;
      return;
    end
    // Filling: append unless equal to the newest entry.
    if (ring_count[ln] < RING_LEN) begin
      last = ring_count[ln] - 1;
      same = 1'b1;
      for (int k = 0; k < NUM_COEF; k++)
        if (ring_hist[ln][last][k] != f[k]) same = 1'b0;
      if (same) return;
      for (int k = 0; k < NUM_COEF; k++) ring_hist[ln][ring_count[ln]][k] = f[k];
      ring_count[ln]++;
      if (ring_count[ln] <= WINDOW_LENGTH)
        for (int k = 0; k < NUM_COEF; k++) window_sum[ln][k] += f[k];
      n = (ring_count[ln] <= WINDOW_LENGTH) ? ring_count[ln] : WINDOW_LENGTH;
      for (int k = 0; k < NUM_COEF; k++) lane_avg[ln][k] = window_sum[ln][k] / longint'(n);
      return;
    end
    // Full ring: drop the oldest, admit the entry WINDOW_LENGTH slots on.
    p      = ring_oldest[ln];
    newest = (p + RING_LEN - 1) % RING_LEN;
    enter  = (p + WINDOW_LENGTH) % RING_LEN;
    same   = 1'b1;
    for (int k = 0; k < NUM_COEF; k++)
      if (ring_hist[ln][newest][k] != f[k]) same = 1'b0;
    if (same) return;
    for (int k = 0; k < NUM_COEF; k++) begin
      old                 = ring_hist[ln][p][k];
      ring_hist[ln][p][k] = f[k];
      window_sum[ln][k]   = window_sum[ln][k] - old + ring_hist[ln][enter][k];
      lane_avg[ln][k]     = window_sum[ln][k] / longint'(WINDOW_LENGTH);
    end
    ring_oldest[ln] = (p + 1) % RING_LEN;
  endfunction

  // Advance the predictor by one accepted frame and return its result.
  function automatic lane_avg_t predict_frame(frame_t fr);
    lane_avg_t res;
    bit        restart;
    longint    gap;
    restart = fr.first_frame | fr.split_seen | fr.new_branch | (fr.branch_grow != 0);
    if (fr.has_fit) begin
      record_fit(0, fr.left, restart);
      record_fit(1, fr.right, restart);
      // Update the width only with both lanes live and no branch growth.
      if ((lane_avg[0][0] | lane_avg[0][1] | lane_avg[0][2]) != 0 &&
          (lane_avg[1][0] | lane_avg[1][1] | lane_avg[1][2]) != 0 &&
          fr.branch_grow == 0) begin
        gap       = lane_avg[1][0] - lane_avg[0][0];
        gap       = (gap < 0) ? -gap : gap;
        width_est = (gap > WIDTH_SAT) ? WIDTH_SAT : gap;
      end
    end
    for (int k = 0; k < NUM_COEF; k++) begin
      res.left[k]  = lane_avg[0][k][PORT_BITS-1:0];
      res.right[k] = lane_avg[1][k][PORT_BITS-1:0];
    end
    res.width = width_est[WIDTH_BITS-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic fit_t mk_fit(int c0, int c1, int c2);
    fit_t f;
    f[0] = c0;
    f[1] = c1;
    f[2] = c2;
    return f;
  endfunction

  // Mix full-range, small, extreme and near-previous coefficients.
  function automatic logic [PORT_BITS-1:0] rand_coef(logic [PORT_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 2000)) - 1000;
      7: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return prev + ($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic fit_t rand_fit(fit_t prev);
    fit_t f;
    if ($urandom_range(0, 29) == 0) return '0;
    for (int k = 0; k < NUM_COEF; k++) f[k] = rand_coef(prev[k]);
    return f;
  endfunction

  task automatic add_frame(int nr, fit_t l, fit_t r, int ini, int spl, int nbr, int grow);
    frame_t fr;
    fr = '{1'(nr), l, r, 1'(ini), 1'(spl), 1'(nbr), 8'(grow)};
    frame_pending.insert(frame_pending.size(), fr);
    if (nr != 0) begin
      last_left  = l;
      last_right = r;
      fits_queued++;
    end
  endtask

  // Fill the pending queue before reset ends: directed frames first, then
  // runs that open with a restart and carry mostly fresh fits.
  initial begin
    int   run_len, pick;
    fit_t l, r;
    int   ini, spl, nbr;
    int   grow;

    // Nothing stored yet, flags ignored without a new result.
    add_frame(0, mk_fit(7, 8, 9), mk_fit(-7, -8, -9), 1, 1, 1, 8'hFF);
    // First fit lands in an empty ring.
    add_frame(1, mk_fit(100, -5, 3), mk_fit(900, 7, -2), 0, 0, 0, 0);
    // Repeated fit on both lanes, then on the right lane only.
    add_frame(1, mk_fit(100, -5, 3), mk_fit(900, 7, -2), 0, 0, 0, 0);
    add_frame(1, mk_fit(120, -4, 2), mk_fit(900, 7, -2), 0, 0, 0, 0);
    add_frame(1, mk_fit(-300, 11, 1), mk_fit(1500, -9, 0), 0, 0, 0, 0);
    // Initial frame at opposite extremes: the width saturates.
    add_frame(1, mk_fit(C_MIN, C_MIN, C_MIN), mk_fit(C_MAX, C_MAX, C_MAX), 1, 0, 0, 0);
    add_frame(1, mk_fit(C_MIN, C_MAX, 0), mk_fit(C_MAX, C_MIN, -1), 0, 0, 0, 0);
    add_frame(1, mk_fit(C_MIN, C_MIN, C_MIN), mk_fit(C_MAX, C_MAX, C_MAX), 0, 0, 0, 0);
    // Split restart with the extremes swapped.
    add_frame(1, mk_fit(C_MAX, C_MAX, C_MAX), mk_fit(C_MIN, C_MIN, C_MIN), 0, 1, 0, 0);
    add_frame(1, mk_fit(C_MAX, C_MAX - 1, 1), mk_fit(C_MIN, C_MIN + 1, -1), 0, 0, 0, 0);
    // New branch with an all-zero left fit: the width holds.
    add_frame(1, mk_fit(0, 0, 0), mk_fit(5, 5, 5), 0, 0, 1, 0);
    add_frame(1, mk_fit(40, 0, 0), mk_fit(5, 5, 5), 0, 0, 0, 0);
    // Branch growth restarts and freezes the width.
    add_frame(1, mk_fit(10, 0, 0), mk_fit(50, 0, 0), 0, 0, 0, 8'd1);
    add_frame(1, mk_fit(-10, 3, 0), mk_fit(70, 0, 2), 0, 0, 0, 8'hFF);
    add_frame(1, mk_fit(-10, 3, 0), mk_fit(70, 0, 2), 0, 0, 0, 8'h80);
    // Every flag at once, then flags on a frame with no new result.
    add_frame(1, mk_fit(-1, -1, -1), mk_fit(1, 1, 1), 1, 1, 1, 8'h55);
    add_frame(0, mk_fit(C_MAX, 0, 0), mk_fit(C_MIN, 0, 0), 1, 0, 1, 8'hAA);
    add_frame(1, mk_fit(-1, -1, -1), mk_fit(3, 1, 1), 0, 0, 0, 0);
    for (int i = 0; i < 5; i++)
      add_frame(1, rand_fit(last_left), rand_fit(last_right), 0, 0, 0, 0);

    fits_queued = 0;
    while (fits_queued < RANDOM_FITS) begin
      // Open each run with a restart of some kind.
      ini  = 0;
      spl  = 0;
      nbr  = 0;
      grow = 0;
      case ($urandom_range(0, 4))
        0: ini  = 1;
        1: spl  = 1;
        2: nbr  = 1;
        3: grow = $urandom_range(1, 255);
        default: begin
          ini  = $urandom_range(0, 1);
          spl  = $urandom_range(0, 1);
          nbr  = $urandom_range(0, 1);
          grow = $urandom_range(0, 255);
          if ((ini | spl | nbr) == 0 && grow == 0) ini = 1;
        end
      endcase
      add_frame(1, rand_fit(last_left), rand_fit(last_right), ini, spl, nbr, grow);
      // Runs of varied length, many long enough to wrap the ring, some very long.
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 40);
      for (int j = 0; j < run_len; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Noise: random content with no new result.
          add_frame(0, fit_t'({$urandom, $urandom, $urandom}),
                    fit_t'({$urandom, $urandom, $urandom}),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 255));
        end else if (pick < 18) begin
          // Repeat the newest fit on one lane or both.
          l = last_left;
          r = last_right;
          case ($urandom_range(0, 2))
            0:       r = rand_fit(last_right);
            1:       l = rand_fit(last_left);
            default: ;
          endcase
          add_frame(1, l, r, 0, 0, 0, 0);
        end else begin
          add_frame(1, rand_fit(last_left), rand_fit(last_right), 0, 0, 0, 0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offer pending items, hold them while stalled, and predict each
  // item as it is accepted. Draw a gap after every item; calm phases run
  // back to back.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait = $urandom_range(0, MAX_WAIT);
    end else begin
      if (in_valid && !in_stall) begin
        avg_expected.insert(avg_expected.size(), predict_frame(cur_frame));
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      // A stalled item stays put; otherwise idle or load the next one.
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (frame_pending.size() != 0) begin
          cur_frame     = frame_pending.pop_front();
          has_fit       <= cur_frame.has_fit;
          left_c0       <= cur_frame.left[0];
          left_c1       <= cur_frame.left[1];
          left_c2       <= cur_frame.left[2];
          right_c0      <= cur_frame.right[0];
          right_c1      <= cur_frame.right[1];
          right_c2      <= cur_frame.right[2];
          first_frame   <= cur_frame.first_frame;
          split_seen    <= cur_frame.split_seen;
          new_branch    <= cur_frame.new_branch;
          branch_grow   <= cur_frame.branch_grow;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction,
  // then draw how long to stall. Once, hold off long enough for the block
  // to fill and stall the driver.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    lane_avg_t want, got;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.left  = {left_avg_c2, left_avg_c1, left_avg_c0};
        got.right = {right_avg_c2, right_avg_c1, right_avg_c0};
        got.width = lane_width;
        if (avg_expected.size() == 0) begin
          $error("result with no frame waiting");
          errors++;
        end else begin
          want = avg_expected.pop_front();
          for (int k = 0; k < NUM_COEF; k++) begin
            if (got.left[k] !== want.left[k]) begin
              $error("left_avg_c%0d: expected %0d, got %0d", k,
                     $signed(want.left[k]), $signed(got.left[k]));
              errors++;
            end
            if (got.right[k] !== want.right[k]) begin
              $error("right_avg_c%0d: expected %0d, got %0d", k,
                     $signed(want.right[k]), $signed(got.right[k]));
              errors++;
            end
          end
          if (got.width !== want.width) begin
            $error("lane_width: expected %0d, got %0d", want.width, got.width);
            errors++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (results_seen == HOLD_OFF_AT) recv_wait = HOLD_OFF_LEN;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Wait for all items to go in and all results to come out, drain, report.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    while (frame_pending.size() != 0 || in_valid) @(negedge clk);
    while (avg_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("[lane_fit_delayed_moving_average] OK");
    end else begin
      $display("[lane_fit_delayed_moving_average] ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("[lane_fit_delayed_moving_average] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ldma_pkg.sv
rtl/ldma_div.sv
rtl/ldma_lane.sv
rtl/lane_fit_delayed_moving_average.sv
tb/sv/testbench.sv
